>>> rtl/ctc_pkg.sv
// ----------------------------------------------------------------------------
// ctc_pkg
// shared types and constants of the four channel counter/timer
// ----------------------------------------------------------------------------
package ctc_pkg;

  localparam int unsigned ChannelsDefault = 4;

  localparam int unsigned OpcodeW  = 3;
  localparam int unsigned ChannelW = 2;
  localparam int unsigned DataW    = 8;
  localparam int unsigned CtrlW    = 7;
  localparam int unsigned PreW     = 9;
  localparam int unsigned PeriodW  = 16;

  // apb side
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  typedef enum logic [OpcodeW-1:0] {
    OP_WRITE  = 3'd0,
    OP_READ   = 3'd1,
    OP_TICK   = 3'd2,
    OP_TRIG   = 3'd3,
    OP_POLL   = 3'd4,
    OP_RETURN = 3'd5
  } op_e;

  typedef enum logic [0:0] {
    REG_TICK_ENABLE = 1'b0,
    REG_EXT_PERIOD  = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    IST_IDLE    = 2'd0,
    IST_PENDING = 2'd1,
    IST_SERVING = 2'd2
  } ist_e;

  typedef enum logic [1:0] {
    PSEL_STOP   = 2'd0,
    PSEL_DIV16  = 2'd1,
    PSEL_DIV256 = 2'd2
  } psel_e;

  localparam logic [PreW-1:0] Div16  = 9'd16;
  localparam logic [PreW-1:0] Div256 = 9'd256;

  // bit positions in the stored control field (control word bit minus one)
  localparam int unsigned CbIntEn   = 6;
  localparam int unsigned CbCounter = 5;
  localparam int unsigned CbDiv256  = 4;
  localparam int unsigned CbTcNext  = 1;
  localparam int unsigned CbReset   = 0;

  localparam logic [DataW-1:0] VecBaseMask = 8'b1111_1000;

  typedef struct packed {
    logic [OpcodeW-1:0]  opcode;
    logic [ChannelW-1:0] channel;
    logic [DataW-1:0]    write_data;
  } item_t;

endpackage

>>> rtl/ctc_in_if.sv
// ----------------------------------------------------------------------------
// ctc_in_if
// input channel of the counter/timer: one command word per handshake
// ----------------------------------------------------------------------------
interface ctc_in_if import ctc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OpcodeW-1:0]  opcode;
  logic [ChannelW-1:0] channel;
  logic [DataW-1:0]    write_data;

  modport source (output valid, output opcode, output channel, output write_data,
                  input ready);
  modport sink (input valid, input opcode, input channel, input write_data,
                output ready);
endinterface

>>> rtl/ctc_out_if.sv
// ----------------------------------------------------------------------------
// ctc_out_if
// result channel of the counter/timer: one result word per handshake
// ----------------------------------------------------------------------------
interface ctc_out_if import ctc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] read_data;
  logic             irq_taken;
  logic [DataW-1:0] vector;

  modport source (output valid, output read_data, output irq_taken, output vector,
                  input ready);
  modport sink (input valid, input read_data, input irq_taken, input vector,
                output ready);
endinterface

>>> rtl/four_channel_counter_timer_unit.sv
// ----------------------------------------------------------------------------
// four_channel_counter_timer_unit
// counter/timer with per-channel down counters and daisy-chain interrupts
// ----------------------------------------------------------------------------
// One command word is taken per clock while in_i.ready is high. A word is
// captured in an input register, executed by combinational logic that updates
// all channels at once, and its result lands in an output register; the
// throughput is one word per cycle as long as the result side keeps up, and
// the input register lets one more word in while a result waits. Ticks,
// triggers, polls and interrupt returns all run through the same update. The
// APB port sets tick enable (offset 0) and the channel 0 trigger period
// (offset 4) and may be written only while no word is in flight.
module four_channel_counter_timer_unit import ctc_pkg::*; #(
  parameter int unsigned CHANNELS = ChannelsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  ctc_in_if.sink              in_i,
  ctc_out_if.source           out_o
);

  // configuration
  logic               tick_en_q;
  logic [PeriodW-1:0] period_q;
  logic               cfg_wr;

  // input register
  logic  s1_valid_q;
  item_t s1_q;
  logic  adv;

  // result register
  logic             out_valid_q;
  logic [DataW-1:0] rdata_q, rdata_d;
  logic             taken_q, taken_d;
  logic [DataW-1:0] vector_q, vector_d;

  // channel state
  logic [CtrlW-1:0]   cb_q    [CHANNELS];
  logic [CtrlW-1:0]   cb_d    [CHANNELS];
  logic [DataW-1:0]   tc_q    [CHANNELS];
  logic [DataW-1:0]   tc_d    [CHANNELS];
  logic [DataW-1:0]   down_q  [CHANNELS];
  logic [DataW-1:0]   down_d  [CHANNELS];
  logic [PreW-1:0]    pcnt_q  [CHANNELS];
  logic [PreW-1:0]    pcnt_d  [CHANNELS];
  psel_e              psel_q  [CHANNELS];
  psel_e              psel_d  [CHANNELS];
  ist_e               ist_q   [CHANNELS];
  ist_e               ist_d   [CHANNELS];
  logic [DataW-1:0]   vbase_q [CHANNELS];
  logic [DataW-1:0]   vbase_d [CHANNELS];
  logic [PeriodW-1:0] ext_cnt_q, ext_cnt_d;

  // per-channel helpers
  logic             ch_hit  [CHANNELS];
  logic             fire    [CHANNELS];
  logic [PreW-1:0]  pc_inc  [CHANNELS];
  logic [PreW-1:0]  pc_div  [CHANNELS];
  logic             pre_hit [CHANNELS];
  logic [DataW-1:0] dc_dec  [CHANNELS];
  logic             zero_hit[CHANNELS];

  logic [PeriodW:0] ext_next;
  logic             ext_wrap;
  logic             ext_fire;
  logic             do_tick;
  op_e              op;

  // --------------------------------------------------------------------------
  // apb configuration
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_en_q <= 1'b0;
      period_q  <= '0;
    end else if (cfg_wr) begin
      case (reg_e'(paddr[2]))
        REG_TICK_ENABLE: tick_en_q <= pwdata[0];
        REG_EXT_PERIOD:  period_q  <= pwdata[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[2]))
      REG_TICK_ENABLE: prdata = {{(ApbDataW-1){1'b0}}, tick_en_q};
      REG_EXT_PERIOD:  prdata = {{(ApbDataW-PeriodW){1'b0}}, period_q};
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // handshake
  // --------------------------------------------------------------------------
  assign adv        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q <= '{opcode: in_i.opcode, channel: in_i.channel, write_data: in_i.write_data};
    end
    if (adv) begin
      rdata_q  <= rdata_d;
      taken_q  <= taken_d;
      vector_q <= vector_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = rdata_q;
  assign out_o.irq_taken = taken_q;
  assign out_o.vector    = vector_q;

  // --------------------------------------------------------------------------
  // tick and trigger sources
  // --------------------------------------------------------------------------
  assign op       = op_e'(s1_q.opcode);
  assign do_tick  = (op == OP_TICK) && tick_en_q;
  assign ext_next = {1'b0, ext_cnt_q} + {{PeriodW{1'b0}}, 1'b1};
  assign ext_wrap = ext_next >= {1'b0, period_q};
  assign ext_fire = ext_wrap && (period_q != '0);

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      ch_hit[i]  = 32'(s1_q.channel) == i;
      pc_inc[i]  = pcnt_q[i] + PreW'(1);
      pc_div[i]  = (psel_q[i] == PSEL_DIV256) ? Div256 : Div16;
      pre_hit[i] = (psel_q[i] != PSEL_STOP) && (pc_inc[i] >= pc_div[i]);
      if (op == OP_TRIG) begin
        fire[i] = ch_hit[i];
      end else if (do_tick) begin
        // channel 0 also fires on the ext trigger; an ext wrap masks its prescaler
        fire[i] = pre_hit[i] && !(i == 0 && ext_wrap);
        if (i == 0) begin
          fire[i] = fire[i] || ext_fire;
        end
      end else begin
        fire[i] = 1'b0;
      end
      dc_dec[i]   = down_q[i] - DataW'(1);
      zero_hit[i] = fire[i] && (dc_dec[i] == '0);
    end
  end

  // --------------------------------------------------------------------------
  // next state of all channels
  // --------------------------------------------------------------------------
  always_comb begin
    logic blocked;
    logic found;

    blocked   = 1'b0;
    found     = 1'b0;
    ext_cnt_d = ext_cnt_q;
    rdata_d   = '0;
    taken_d   = 1'b0;
    vector_d  = '0;

    if (do_tick) begin
      ext_cnt_d = ext_wrap ? '0 : ext_next[PeriodW-1:0];
    end

    for (int i = 0; i < CHANNELS; i++) begin
      cb_d[i]    = cb_q[i];
      tc_d[i]    = tc_q[i];
      down_d[i]  = down_q[i];
      pcnt_d[i]  = pcnt_q[i];
      psel_d[i]  = psel_q[i];
      ist_d[i]   = ist_q[i];
      vbase_d[i] = vbase_q[i];

      if (do_tick && psel_q[i] != PSEL_STOP) begin
        pcnt_d[i] = pre_hit[i] ? '0 : pc_inc[i];
      end
      if (fire[i]) begin
        down_d[i] = (dc_dec[i] == '0) ? tc_q[i] : dc_dec[i];
      end

      if (op == OP_WRITE && ch_hit[i]) begin
        if (cb_q[i][CbTcNext]) begin
          cb_d[i][CbTcNext] = 1'b0;
          tc_d[i]           = s1_q.write_data;
          down_d[i]         = s1_q.write_data;
          pcnt_d[i]         = '0;
          if (cb_q[i][CbCounter]) begin
            psel_d[i] = PSEL_STOP;
          end else begin
            psel_d[i] = cb_q[i][CbDiv256] ? PSEL_DIV256 : PSEL_DIV16;
          end
        end else if (s1_q.write_data[0]) begin
          cb_d[i] = s1_q.write_data[DataW-1:1];
          if (s1_q.write_data[CbReset+1]) begin
            psel_d[i] = PSEL_STOP;
          end
        end else begin
          vbase_d[i] = s1_q.write_data & VecBaseMask;
        end
      end

      if (op == OP_READ && ch_hit[i]) begin
        rdata_d = {cb_q[i], 1'b0};
      end

      // daisy chain: a reload may raise a request only if every channel numbered at
      // or below it is idle, lowest numbered reload wins
      blocked = blocked || (ist_q[i] != IST_IDLE);
      if (zero_hit[i] && cb_q[i][CbIntEn] && !blocked) begin
        ist_d[i] = IST_PENDING;
        blocked  = 1'b1;
      end

      if (op == OP_POLL && !found && ist_q[i] != IST_IDLE) begin
        found = 1'b1;
        if (ist_q[i] == IST_PENDING) begin
          ist_d[i] = IST_SERVING;
          taken_d  = 1'b1;
        end
      end

      if (op == OP_RETURN && !found && ist_q[i] == IST_SERVING) begin
        found    = 1'b1;
        ist_d[i] = IST_IDLE;
      end
    end

    // vector of the highest priority channel in service, after this word
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (ist_d[i] == IST_SERVING) begin
        vector_d = vbase_d[i] + DataW'(2 * i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_q      <= '{default: '0};
      tc_q      <= '{default: '0};
      down_q    <= '{default: '0};
      pcnt_q    <= '{default: '0};
      psel_q    <= '{default: PSEL_STOP};
      ist_q     <= '{default: IST_IDLE};
      vbase_q   <= '{default: '0};
      ext_cnt_q <= '0;
    end else if (adv) begin
      cb_q      <= cb_d;
      tc_q      <= tc_d;
      down_q    <= down_d;
      pcnt_q    <= pcnt_d;
      psel_q    <= psel_d;
      ist_q     <= ist_d;
      vbase_q   <= vbase_d;
      ext_cnt_q <= ext_cnt_d;
    end
  end

endmodule
